// ----- rtl/spq_pkg.sv -----
package spq_pkg;

    localparam int CAPACITY = 16;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int OCC_W    = $clog2(CAPACITY + 1);
    localparam int VALUE_W  = 32;
    localparam int COUNT_W  = 5;

    localparam logic KIND_ENQ = 1'b0;
    localparam logic KIND_DEQ = 1'b1;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_UNDERFLOW = 2'd1;
    localparam logic [1:0] STATUS_FULL      = 2'd2;

    localparam logic signed [VALUE_W-1:0] EMPTY_VALUE = -32'sd1;

    typedef struct packed {
        logic                      kind;
        logic signed [VALUE_W-1:0] value;
    } req_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] out_value;
        logic [1:0]                status;
        logic [COUNT_W-1:0]        count;
    } rsp_t;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_READ = 5'b00010,
        S_CMP  = 5'b00100,
        S_PUT  = 5'b01000,
        S_FIN  = 5'b10000
    } state_t;

endpackage

// ----- rtl/spq_ram.sv -----
module spq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/sorted_insert_priority_queue.sv -----
// a rejected insert, an empty dequeue or an insert into an empty queue goes to S_FIN;
// dequeue: S_READ, S_CMP, S_FIN; insert: S_READ, S_CMP per entry, S_PUT if all larger, S_FIN
// throughput: one word at a time; the next word is taken the cycle after the result loads
// an insert walks the ring memory from the tail, reading in S_READ and writing back in S_CMP
// reset (rst_n low, asynchronous) empties the queue at once; memory contents are not cleared
module sorted_insert_priority_queue (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         req_valid,
    output logic         req_ready,
    input  spq_pkg::req_t req,
    output logic         rsp_valid,
    input  logic         rsp_ready,
    output spq_pkg::rsp_t rsp
);

    import spq_pkg::*;

    state_t                    state_reg, state_next;
    logic [IDX_W-1:0]          head_reg, head_next;
    logic [IDX_W-1:0]          idx_reg, idx_next;
    logic [OCC_W-1:0]          occ_reg, occ_next;
    logic                      deq_reg, deq_next;
    logic signed [VALUE_W-1:0] val_reg, val_next;
    logic signed [VALUE_W-1:0] res_val_reg, res_val_next;
    logic [1:0]                res_status_reg, res_status_next;
    logic                      rsp_valid_reg, rsp_valid_next;
    rsp_t                      rsp_reg, rsp_next;

    logic                      wr_en;
    logic [IDX_W-1:0]          wr_addr;
    logic [VALUE_W-1:0]        wr_data;
    logic                      rd_en;
    logic [IDX_W-1:0]          rd_addr;
    logic [VALUE_W-1:0]        rd_data;
    logic signed [VALUE_W-1:0] rd_value;

    logic [OCC_W-1:0]          occ_m1;
    logic [IDX_W-1:0]          idx_inc;
    logic [31:0]               occ_ext;

    // logical position to ring address
    function automatic logic [IDX_W-1:0] phys(input logic [IDX_W-1:0] base,
                                              input logic [IDX_W-1:0] off);
        logic [IDX_W:0] sum;
        sum = {1'b0, base} + {1'b0, off};
        if (sum >= (IDX_W+1)'(CAPACITY))
        begin
            sum = sum - (IDX_W+1)'(CAPACITY);
        end
        return sum[IDX_W-1:0];
    endfunction

    spq_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign rd_value = rd_data;
    assign occ_m1   = occ_reg - OCC_W'(1);
    assign idx_inc  = idx_reg + IDX_W'(1);
    assign occ_ext  = 32'(occ_reg);

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_comb
    begin
        state_next      = state_reg;
        head_next       = head_reg;
        idx_next        = idx_reg;
        occ_next        = occ_reg;
        deq_next        = deq_reg;
        val_next        = val_reg;
        res_val_next    = res_val_reg;
        res_status_next = res_status_reg;
        rsp_valid_next  = rsp_valid_reg & ~rsp_ready;
        rsp_next        = rsp_reg;
        wr_en           = 1'b0;
        wr_addr         = phys(head_reg, idx_inc);
        wr_data         = val_reg;
        rd_en           = 1'b0;
        rd_addr         = phys(head_reg, idx_reg);

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    deq_next        = (req.kind == KIND_DEQ);
                    val_next        = req.value;
                    res_val_next    = '0;
                    res_status_next = STATUS_OK;
                    if (req.kind == KIND_DEQ)
                    begin
                        if (occ_reg == '0)
                        begin
                            res_val_next    = EMPTY_VALUE;
                            res_status_next = STATUS_UNDERFLOW;
                            state_next      = S_FIN;
                        end
                        else
                        begin
                            idx_next   = '0;
                            state_next = S_READ;
                        end
                    end
                    else if (occ_reg == OCC_W'(CAPACITY))
                    begin
                        res_status_next = STATUS_FULL;
                        state_next      = S_FIN;
                    end
                    else if (occ_reg == '0)
                    begin
                        wr_en      = 1'b1;
                        wr_addr    = head_reg;
                        wr_data    = req.value;
                        occ_next   = occ_reg + OCC_W'(1);
                        state_next = S_FIN;
                    end
                    else
                    begin
                        // start from the tail and move larger entries up
                        idx_next   = occ_m1[IDX_W-1:0];
                        state_next = S_READ;
                    end
                end
            end

            S_READ:
            begin
                rd_en      = 1'b1;
                state_next = S_CMP;
            end

            S_CMP:
            begin
                if (deq_reg)
                begin
                    res_val_next = rd_value;
                    head_next    = phys(head_reg, IDX_W'(1));
                    occ_next     = occ_m1;
                    state_next   = S_FIN;
                end
                else if (rd_value > val_reg)
                begin
                    wr_en   = 1'b1;
                    wr_data = rd_data;
                    if (idx_reg == '0)
                    begin
                        state_next = S_PUT;
                    end
                    else
                    begin
                        idx_next   = idx_reg - IDX_W'(1);
                        state_next = S_READ;
                    end
                end
                else
                begin
                    // equal or smaller entry found: new value sits just above it
                    wr_en      = 1'b1;
                    occ_next   = occ_reg + OCC_W'(1);
                    state_next = S_FIN;
                end
            end

            S_PUT:
            begin
                wr_en      = 1'b1;
                wr_addr    = head_reg;
                occ_next   = occ_reg + OCC_W'(1);
                state_next = S_FIN;
            end

            S_FIN:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_next.out_value = res_val_reg;
                    rsp_next.status    = res_status_reg;
                    rsp_next.count     = occ_ext[COUNT_W-1:0];
                    rsp_valid_next     = 1'b1;
                    state_next         = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            idx_reg       <= '0;
            occ_reg       <= '0;
            deq_reg       <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            idx_reg       <= idx_next;
            occ_reg       <= occ_next;
            deq_reg       <= deq_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg        <= val_next;
        res_val_reg    <= res_val_next;
        res_status_reg <= res_status_next;
        rsp_reg        <= rsp_next;
    end

endmodule
